>>> rtl/zcmd_pkg.sv
package zcmd_pkg;

   localparam int GridSideDef     = 64;
   localparam int PosFracBitsDef  = 20;
   localparam int MassFracBitsDef = 16;

   localparam int ACTION_W  = 2;
   localparam int CELL_W    = 6;
   localparam int DISP_W    = 24;
   localparam int GROWTH_W  = 16;
   localparam int MASS_W    = 32;
   localparam int COUNT_W   = 24;
   localparam int STATUS_W  = 2;
   localparam int CONTR_FRAC = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DEPOSIT = 2'd0,
      ACT_READ    = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WIPE,
      S_AXIS,
      S_WXY,
      S_WGT,
      S_RDM,
      S_ADD,
      S_RDC,
      S_DIV,
      S_DONE
   } state_type;

endpackage

>>> rtl/zcmd_div.sv
// Restoring divider, one quotient bit per cycle.
module zcmd_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      trial  = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in   = num;
         r_in   = '0;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign busy = (cnt_ff != '0);
   assign quo  = q_ff;
endmodule

>>> rtl/zcmd_grid.sv
// Grid mass store, one port, registered read.
module zcmd_grid #(
   parameter int ADDR_W = 18
) (
   input  logic                            clock,
   input  logic                            we,
   input  logic [ADDR_W-1:0]               addr,
   input  logic [zcmd_pkg::MASS_W-1:0]     wdata,
   output logic [zcmd_pkg::MASS_W-1:0]     rdata
);
   import zcmd_pkg::*;

   logic [MASS_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> rtl/zeldovich_cic_mass_deposit_top.sv
// Deposit: axis steps for x, y and z, pair-weight steps, then weight, read and add per corner, then done.
// Read: cell read, then the divider, then done; the divider is not started with no particles.
// Clear: a wipe pass over the grid, then done. One word in progress; the next is taken the cycle after
// done. A result waiting in the output register stalls only at done.
// After reset a clearing pass over all GRID_SIDE^3 cells runs through the grid memory
// before the first word is accepted; count and the growth register reset to zero.
module zeldovich_cic_mass_deposit_top #(
   parameter int GRID_SIDE      = zcmd_pkg::GridSideDef,
   parameter int POS_FRAC_BITS  = zcmd_pkg::PosFracBitsDef,
   parameter int MASS_FRAC_BITS = zcmd_pkg::MassFracBitsDef
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [zcmd_pkg::GROWTH_W-1:0]       csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [zcmd_pkg::ACTION_W-1:0]       req_action,
   input  logic [zcmd_pkg::CELL_W-1:0]         req_cell_x,
   input  logic [zcmd_pkg::CELL_W-1:0]         req_cell_y,
   input  logic [zcmd_pkg::CELL_W-1:0]         req_cell_z,
   input  logic signed [zcmd_pkg::DISP_W-1:0]  req_disp_x,
   input  logic signed [zcmd_pkg::DISP_W-1:0]  req_disp_y,
   input  logic signed [zcmd_pkg::DISP_W-1:0]  req_disp_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [zcmd_pkg::MASS_W-1:0]         rsp_cell_density,
   output logic signed [31:0]                  rsp_contrast,
   output logic [zcmd_pkg::STATUS_W-1:0]       rsp_status
);
   import zcmd_pkg::*;

   localparam int LOG_G  = $clog2(GRID_SIDE);
   localparam int ADDR_W = 3 * LOG_G;
   localparam int PF     = POS_FRAC_BITS;
   localparam int MF     = MASS_FRAC_BITS;
   localparam int PROD_W = ((DISP_W > PF + 1) ? DISP_W : PF + 1) + 1;
   localparam int GW     = PF + LOG_G + 2;
   localparam int NUM_W  = MASS_W + ADDR_W + 16;
   localparam int DEN_W  = COUNT_W + 16;
   localparam logic [MASS_W-1:0]  MASS_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [MF:0]        MASS_ONE  = (MF+1)'(1) << MF;

   state_type state_ff, state_in;

   logic [GROWTH_W-1:0]  growth_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W:0]      wipe_ff, wipe_in;
   logic [1:0]           ax_ff, ax_in;
   logic [2:0]           corner_ff, corner_in;
   action_type           act_ff;
   logic [LOG_G-1:0]     cx_ff, cy_ff, cz_ff;
   logic signed [DISP_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [LOG_G-1:0]     lo_ff [3];
   logic [PF-1:0]        fr_ff [3];
   logic [PF:0]          wxy_ff [4];   // wx*wy, indexed {a, b}
   logic [MF:0]          w_ff, used_ff;
   logic                 sat_ff;
   logic [MASS_W-1:0]    dens_ff;
   logic signed [31:0]   contr_ff;
   status_type           stat_ff;
   logic                 rv_ff;
   logic [MASS_W-1:0]    rsp_dens_ff;
   logic signed [31:0]   rsp_contr_ff;
   status_type           rsp_stat_ff;
   logic                 done_go;

   // ---------------- shared multiplier ----------------
   logic signed [PROD_W-1:0]   mul_a, mul_b;
   logic signed [2*PROD_W-1:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // per-axis selections
   logic [LOG_G-1:0]         sel_c;
   logic signed [DISP_W-1:0] sel_d;
   always_comb begin
      unique case (ax_ff)
         2'd0:    begin sel_c = cx_ff; sel_d = dx_ff; end
         2'd1:    begin sel_c = cy_ff; sel_d = dy_ff; end
         default: begin sel_c = cz_ff; sel_d = dz_ff; end
      endcase
   end

   logic ca, cb, cc;
   assign ca = corner_ff[2];
   assign cb = corner_ff[1];
   assign cc = corner_ff[0];

   function automatic logic [PF:0] wsel(input logic hi, input logic [PF-1:0] f);
      wsel = hi ? {1'b0, f} : ((PF+1)'(1) << PF) - {1'b0, f};
   endfunction

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_AXIS: begin
            mul_a = PROD_W'($signed({1'b0, growth_ff}));
            mul_b = PROD_W'(sel_d);
         end
         S_WXY: begin
            mul_a = PROD_W'($signed({1'b0, wsel(ax_ff[0], fr_ff[0])}));
            mul_b = PROD_W'($signed({1'b0, wsel(ax_ff[1], fr_ff[1])}));
         end
         S_WGT: begin
            mul_a = PROD_W'($signed({1'b0, wxy_ff[{ca, cb}]}));
            mul_b = PROD_W'($signed({1'b0, wsel(cc, fr_ff[2])}));
         end
         default: ;
      endcase
   end

   // axis datapath
   logic signed [PROD_W-1:0] off;
   logic [PF-1:0]            centre, pos;
   logic [GW-1:0]            g;
   always_comb begin
      off    = PROD_W'(mul_p >>> 8);
      centre = PF'(((2 * {{(PF-LOG_G){1'b0}}, sel_c} + 1'b1) << PF) >> (LOG_G + 1));
      pos    = centre + off[PF-1:0];
      g      = (GW'(pos) << LOG_G) + (GW'(1) << (PF + LOG_G)) - (GW'(1) << (PF - 1));
   end

   logic [MF:0] wraw;
   assign wraw = (MF+1)'(mul_p >> (2 * PF - MF));

   // ---------------- grid memory ----------------
   logic [LOG_G-1:0]  ix, iy, iz;
   logic [ADDR_W-1:0] addr;
   logic              mem_we;
   logic [MASS_W-1:0] mem_wd, mem_rd;
   logic [MASS_W:0]   msum;

   assign ix = lo_ff[0] + LOG_G'(ca);
   assign iy = lo_ff[1] + LOG_G'(cb);
   assign iz = lo_ff[2] + LOG_G'(cc);
   assign msum = {1'b0, mem_rd} + (MASS_W+1)'(w_ff);

   always_comb begin
      addr   = {ix, iy, iz};
      mem_we = 1'b0;
      mem_wd = msum[MASS_W] ? MASS_MAX : msum[MASS_W-1:0];
      priority case (state_ff)
         S_WIPE: begin
            addr   = wipe_ff[ADDR_W-1:0];
            mem_we = 1'b1;
            mem_wd = '0;
         end
         // read cell fetched at the accepting edge, data ready in S_RDC
         S_IDLE: addr = {LOG_G'(req_cell_x), LOG_G'(req_cell_y), LOG_G'(req_cell_z)};
         S_ADD: mem_we = 1'b1;
         default: ;
      endcase
   end

   zcmd_grid #(.ADDR_W(ADDR_W)) u_grid (
      .clock (clock),
      .we    (mem_we),
      .addr  (addr),
      .wdata (mem_wd),
      .rdata (mem_rd)
   );

   // ---------------- divider ----------------
   logic             div_start, div_busy;
   logic [NUM_W-1:0] div_num, div_q;
   logic [DEN_W-1:0] div_den;
   always_comb begin
      if (MF >= 16) begin
         div_num = NUM_W'(mem_rd) << ADDR_W;
         div_den = DEN_W'(count_ff) << (MF - 16);
      end else begin
         div_num = NUM_W'(mem_rd) << (ADDR_W + 16 - MF);
         div_den = DEN_W'(count_ff);
      end
   end
   assign div_start = (state_ff == S_RDC) && (count_ff != '0);

   zcmd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_q)
   );

   localparam logic [NUM_W-1:0] QLIM = NUM_W'(64'h7FFF_FFFF) + NUM_W'(65536);

   // result moves to the output register once it is free or being taken
   assign done_go = (state_ff == S_DONE) && (!rv_ff || rsp_ready);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            unique case (action_type'(req_action))
               ACT_DEPOSIT: state_in = S_AXIS;
               ACT_READ:    state_in = S_RDC;
               ACT_CLEAR:   state_in = S_WIPE;
               default:     state_in = S_DONE;
            endcase
         end
         // the pass after reset ends without a result
         S_WIPE: if (wipe_ff[ADDR_W-1:0] == '1)
            state_in = (act_ff == ACT_CLEAR) ? S_DONE : S_IDLE;
         S_AXIS: if (ax_ff == 2'd2) state_in = S_WXY;
         S_WXY:  if (ax_ff == 2'd3) state_in = S_WGT;
         S_WGT:  state_in = S_RDM;
         S_RDM:  state_in = S_ADD;
         S_ADD:  state_in = (corner_ff == 3'd7) ? S_DONE : S_WGT;
         S_RDC:  state_in = S_DIV;
         S_DIV:  if (!div_busy || count_ff == '0) state_in = S_DONE;
         S_DONE: if (done_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      wipe_in   = wipe_ff;
      ax_in     = ax_ff;
      corner_in = corner_ff;
      count_in  = count_ff;
      unique case (state_ff)
         S_IDLE:  begin ax_in = '0; corner_in = '0; wipe_in = '0; end
         S_WIPE:  wipe_in = wipe_ff + 1'b1;
         S_AXIS:  ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 1'b1;
         S_WXY:   ax_in = ax_ff + 1'b1;
         S_ADD:   begin
            corner_in = corner_ff + 1'b1;
            if (corner_ff == 3'd7 && count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
         end
         default: ;
      endcase
      if (state_ff == S_WIPE && act_ff == ACT_CLEAR) count_in = '0;
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_WIPE;
         growth_ff <= '0;
         count_ff  <= '0;
         wipe_ff   <= '0;
         ax_ff     <= '0;
         corner_ff <= '0;
         rv_ff     <= 1'b0;
         act_ff    <= ACT_NOP;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         wipe_ff   <= wipe_in;
         ax_ff     <= ax_in;
         corner_ff <= corner_in;
         if (csr_write_enable) growth_ff <= csr_write_data;
         if (done_go) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
         if (req_valid && req_ready) act_ff <= action_type'(req_action);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cx_ff   <= LOG_G'(req_cell_x);
         cy_ff   <= LOG_G'(req_cell_y);
         cz_ff   <= LOG_G'(req_cell_z);
         dx_ff   <= req_disp_x;
         dy_ff   <= req_disp_y;
         dz_ff   <= req_disp_z;
         used_ff <= '0;
         sat_ff  <= 1'b0;
         dens_ff <= '0;
         contr_ff <= '0;
         stat_ff <= ST_OK;
      end
      if (state_ff == S_AXIS) begin
         lo_ff[ax_ff] <= g[PF +: LOG_G];
         fr_ff[ax_ff] <= g[PF-1:0];
      end
      // WXY runs ax = 0..3 with a = ax[0], b = ax[1]
      if (state_ff == S_WXY) wxy_ff[{ax_ff[0], ax_ff[1]}] <= (PF+1)'(mul_p >> PF);
      if (state_ff == S_WGT) begin
         if (corner_ff == 3'd7) w_ff <= MASS_ONE - used_ff;
         else begin
            w_ff    <= wraw;
            used_ff <= used_ff + wraw;
         end
      end
      if (state_ff == S_ADD && msum[MASS_W]) sat_ff <= 1'b1;
      if (state_ff == S_ADD && corner_ff == 3'd7) begin
         stat_ff <= (sat_ff || msum[MASS_W] || count_ff == COUNT_MAX) ? ST_SAT : ST_OK;
      end
      if (state_ff == S_RDC) begin
         dens_ff <= mem_rd;
         if (count_ff == '0) stat_ff <= ST_EMPTY;
         else if (mem_rd == MASS_MAX || count_ff == COUNT_MAX) stat_ff <= ST_SAT;
      end
      if (state_ff == S_DIV && !div_busy && count_ff != '0 && act_ff == ACT_READ) begin
         if (div_q > QLIM) begin
            contr_ff <= 32'sh7FFF_FFFF;
            stat_ff  <= ST_SAT;
         end else begin
            contr_ff <= 32'(div_q - NUM_W'(65536));
         end
      end
      if (done_go) begin
         rsp_dens_ff  <= dens_ff;
         rsp_contr_ff <= contr_ff;
         rsp_stat_ff  <= stat_ff;
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_cell_density = rsp_dens_ff;
   assign rsp_contrast     = rsp_contr_ff;
   assign rsp_status       = rsp_stat_ff;

   // ---------------- checks ----------------
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("accept while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == S_DONE) else $error("response without done");
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_WIPE) |=> count_ff >= $past(count_ff)) else $error("count dropped");
endmodule

>>> tb/zeldovich_cic_mass_deposit_top_test.sv
module zeldovich_cic_mass_deposit_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import zcmd_pkg::*;

   localparam int SIDE = 64;
   localparam longint unsigned FRAC_MASK = 64'hFFFFF;
   localparam longint unsigned UNIT_MASS = 64'd65536;
   localparam longint unsigned MASS_TOP = 64'hFFFF_FFFF;
   localparam bit [23:0] COUNT_TOP = 24'hFFFFFF;

   typedef struct {
      logic [31:0] density;
      logic [31:0] contrast;
      logic [1:0]  status;
   } cell_result;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [GROWTH_W-1:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic [CELL_W-1:0] req_cell_x = '0, req_cell_y = '0, req_cell_z = '0;
   logic signed [DISP_W-1:0] req_disp_x = '0, req_disp_y = '0, req_disp_z = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [MASS_W-1:0] rsp_cell_density;
   logic signed [31:0] rsp_contrast;
   logic [STATUS_W-1:0] rsp_status;

   zeldovich_cic_mass_deposit_top DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y), .req_cell_z(req_cell_z),
      .req_disp_x(req_disp_x), .req_disp_y(req_disp_y), .req_disp_z(req_disp_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cell_density(rsp_cell_density), .rsp_contrast(rsp_contrast),
      .rsp_status(rsp_status)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // shadow grid state
   int unsigned grid_mass[int];
   bit [23:0] particles;
   bit [15:0] growth;

   cell_result pending_results[$];
   int errors = 0;
   int burst_left = 0;
   int hold_left = 0;
   int seen_cells[$];

   function automatic int cell_slot(longint unsigned x, longint unsigned y, longint unsigned z);
      return int'(((x % SIDE) * SIDE + (y % SIDE)) * SIDE + (z % SIDE));
   endfunction

   function automatic void place_axis(input bit [5:0] c, input logic signed [23:0] d,
                                      output longint unsigned lo, output longint unsigned fr);
      longint centre, prod, off;
      longint unsigned pos, g;
      centre = ((2 * longint'(c) + 1) <<< 20) / (2 * SIDE);
      prod = longint'(growth) * longint'(d);
      off = prod >= 0 ? prod / 256 : -((-prod + 255) / 256);
      pos = longint'(centre + off) & FRAC_MASK;
      g = pos * SIDE + SIDE * 64'd1048576 - 64'd524288;
      lo = (g >> 20) % SIDE;
      fr = g & FRAC_MASK;
   endfunction

   function automatic cell_result predict_cic(input logic [1:0] act, input bit [5:0] cx,
      input bit [5:0] cy, input bit [5:0] cz, input logic signed [23:0] dx,
      input logic signed [23:0] dy, input logic signed [23:0] dz);
      cell_result r;
      longint unsigned lo[3], fr[3], wx, wy, wz, wxy, w, used, s, m, q;
      longint v;
      int slot;
      bit sat;
      r.density = 0;
      r.contrast = 0;
      r.status = ST_OK;
      case (act)
         ACT_DEPOSIT: begin
            sat = 0;
            used = 0;
            place_axis(cx, dx, lo[0], fr[0]);
            place_axis(cy, dy, lo[1], fr[1]);
            place_axis(cz, dz, lo[2], fr[2]);
            for (int a = 0; a < 2; a++) begin
               wx = a ? fr[0] : 64'd1048576 - fr[0];
               for (int b = 0; b < 2; b++) begin
                  wy = b ? fr[1] : 64'd1048576 - fr[1];
                  wxy = (wx * wy) >> 20;
                  for (int c = 0; c < 2; c++) begin
                     wz = c ? fr[2] : 64'd1048576 - fr[2];
                     if (a && b && c) w = UNIT_MASS - used;
                     else begin
                        w = (wxy * wz) >> 24;
                        used += w;
                     end
                     slot = cell_slot(lo[0] + a, lo[1] + b, lo[2] + c);
                     s = (grid_mass.exists(slot) ? grid_mass[slot] : 0) + w;
                     if (s > MASS_TOP) begin
                        s = MASS_TOP;
                        sat = 1;
                     end
                     grid_mass[slot] = 32'(s);
                  end
               end
            end
            if (particles == COUNT_TOP) sat = 1;
            else particles++;
            if (sat) r.status = ST_SAT;
         end
         ACT_READ: begin
            slot = cell_slot(cx, cy, cz);
            m = grid_mass.exists(slot) ? grid_mass[slot] : 0;
            r.density = 32'(m);
            if (particles == 0) r.status = ST_EMPTY;
            else begin
               sat = 0;
               q = (m * SIDE * SIDE * SIDE) / particles;
               if (q > 64'h7FFF_FFFF + 65536) begin
                  v = 64'h7FFF_FFFF;
                  sat = 1;
               end else v = longint'(q) - 65536;
               r.contrast = v[31:0];
               if (sat || m == MASS_TOP || particles == COUNT_TOP) r.status = ST_SAT;
            end
         end
         ACT_CLEAR: begin
            grid_mass.delete();
            particles = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // sender: bursts with random gaps
   task automatic send_word(input logic [1:0] act, input bit [5:0] cx, input bit [5:0] cy,
      input bit [5:0] cz, input logic signed [23:0] dx, input logic signed [23:0] dy,
      input logic signed [23:0] dz);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock) req_valid = 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1;
      req_action = act;
      req_cell_x = cx; req_cell_y = cy; req_cell_z = cz;
      req_disp_x = dx; req_disp_y = dy; req_disp_z = dz;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_cic(act, cx, cy, cz, dx, dy, dz));
   endtask

   task automatic drain;
      @(negedge clock) req_valid = 0;
      wait (pending_results.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_growth(input bit [15:0] value);
      drain();
      @(negedge clock);
      csr_write_enable = 1;
      csr_write_data = value;
      growth = value;
      @(negedge clock) csr_write_enable = 0;
   endtask

   function automatic logic signed [23:0] pick_disp();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return $signed(24'($urandom_range(0, 8191) - 4096));
         2: return $signed(24'($urandom_range(0, 511) - 256));
         default: return 0;
      endcase
   endfunction

   task automatic random_deposit();
      bit [5:0] cx, cy, cz;
      cx = 6'($urandom); cy = 6'($urandom); cz = 6'($urandom);
      if (seen_cells.size() > 0 && $urandom_range(0, 2) == 0) begin
         cx = 6'(seen_cells[$urandom_range(0, seen_cells.size() - 1)] >> 12);
         cy = 6'(seen_cells[0] >> 6);
      end
      seen_cells.push_back(cell_slot(cx, cy, cz));
      if (seen_cells.size() > 32) void'(seen_cells.pop_front());
      send_word(ACT_DEPOSIT, cx, cy, cz, pick_disp(), pick_disp(), pick_disp());
   endtask

   task automatic random_read();
      int slot;
      bit [5:0] cx, cy, cz;
      cx = 6'($urandom); cy = 6'($urandom); cz = 6'($urandom);
      if (seen_cells.size() > 0 && $urandom_range(0, 3) != 0) begin
         slot = seen_cells[$urandom_range(0, seen_cells.size() - 1)];
         // hit the home cell or one of its neighbors
         cx = 6'((slot >> 12) + $urandom_range(0, 1));
         cy = 6'((slot >> 6) + $urandom_range(0, 1));
         cz = 6'(slot + $urandom_range(0, 1));
      end
      send_word(ACT_READ, cx, cy, cz, 24'($urandom), 24'($urandom), 24'($urandom));
   endtask

   task automatic test_directed;
      write_growth(16'h0000);
      send_word(ACT_READ, 0, 0, 0, 0, 0, 0);
      // exact centre: whole unit to home cell, contrast saturates
      send_word(ACT_DEPOSIT, 0, 0, 0, 24'sh7FFFFF, -24'sh800000, 0);
      send_word(ACT_READ, 0, 0, 0, 0, 0, 0);
      send_word(ACT_DEPOSIT, 63, 63, 63, -24'sh800000, 24'sh7FFFFF, -1);
      send_word(ACT_READ, 63, 63, 63, 0, 0, 0);
      send_word(ACT_READ, 0, 0, 1, 0, 0, 0);
      send_word(ACT_NOP, 63, 63, 63, -1, -1, -1);
      write_growth(16'hFFFF);
      send_word(ACT_DEPOSIT, 63, 0, 63, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
      send_word(ACT_DEPOSIT, 0, 63, 0, -1, 1, 0);
      send_word(ACT_DEPOSIT, 31, 32, 33, 24'sh000100, -24'sh000100, 24'sh00FFFF);
      send_word(ACT_READ, 63, 0, 63, 0, 0, 0);
      send_word(ACT_READ, 0, 63, 0, 0, 0, 0);
      send_word(ACT_READ, 31, 32, 33, 0, 0, 0);
      write_growth(16'h0100);
      send_word(ACT_DEPOSIT, 10, 10, 10, 24'sh004000, 24'sh002000, -24'sh001000);
      send_word(ACT_READ, 10, 10, 10, 0, 0, 0);
      send_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
      send_word(ACT_READ, 0, 0, 0, 0, 0, 0);
      send_word(ACT_DEPOSIT, 5, 6, 7, 0, 0, 0);
      send_word(ACT_READ, 5, 6, 7, 0, 0, 0);
   endtask

   task automatic test_random;
      bit [15:0] settings[4];
      int pick;
      settings = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0000};
      settings[3] = 16'($urandom);
      for (int ph = 0; ph < 4; ph++) begin
         write_growth(settings[ph]);
         for (int n = 0; n < 110; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 58) random_deposit();
            else if (pick < 95) random_read();
            else send_word(ACT_NOP, 6'($urandom), 6'($urandom), 6'($urandom),
                           24'($urandom), 24'($urandom), 24'($urandom));
         end
         if (ph == 1) send_word(ACT_CLEAR, 6'($urandom), 6'($urandom), 6'($urandom),
                                24'($urandom), 0, 0);
      end
   endtask

   task automatic test_backpressure;
      drain();
      @(posedge clock) hold_left = 300;
      for (int n = 0; n < 20; n++) begin
         if (n[0]) random_read();
         else random_deposit();
      end
      drain();
   endtask

   // receiver stall pattern, cycles through three ready modes
   always @(negedge clock) begin
      int mode;
      mode = int'($realtime / 1280) % 3;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else if (mode == 0) rsp_ready <= 1;
      else if (mode == 1) rsp_ready <= $urandom_range(0, 3) != 0;
      else rsp_ready <= $urandom_range(0, 2) == 0;
   end

   always @(posedge clock) begin
      cell_result want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) report_mismatch("unexpected word", 0, 0);
         else begin
            want = pending_results.pop_front();
            if (rsp_cell_density !== want.density)
               report_mismatch("cell_density", rsp_cell_density, want.density);
            if (rsp_contrast !== want.contrast)
               report_mismatch("contrast", rsp_contrast, want.contrast);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   initial begin
      #200ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      repeat (4) @(negedge clock);
      reset = 0;
      test_directed();
      test_random();
      test_backpressure();
      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule
